/* hw/rtl/lpht_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table package
// Shared widths, codes and request/response types of the hash table block.
// ----------------------------------------------------------------------------
package lpht_pkg;

   localparam int KEY_W          = 31;
   localparam int STATUS_W       = 2;
   localparam int SLOT_W         = 8;
   localparam int TABLE_SIZE_DEF = 16;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic             opcode;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
   } rsp_type;

endpackage

/* hw/rtl/linear_probe_hash_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table
// Open-addressing hash table with linear probing, insert and delete requests.
// ----------------------------------------------------------------------------
// One request is handled at a time and req_ready is high only while the block
// is idle. Every home slot is found by a shared remainder unit that multiplies
// by the reciprocal of the table size. An insert then probes one slot a cycle.
// While searching, a delete reads each stored key and then compares it. It
// then walks the following cluster, reading each entry and recomputing its
// home; each entry moved is placed again at one probe a cycle. The result
// waits in an output register, so the next request may enter before the
// previous response is taken.
module linear_probe_hash_table
   import lpht_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IW = $clog2(TABLE_SIZE);
   localparam int CW = $clog2(TABLE_SIZE + 1);
   localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_SIZE - 1);
   localparam logic [CW-1:0] LAST_PROBE = CW'(TABLE_SIZE - 1);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_HMOD  = 9'b000000010,
      ST_PLACE = 9'b000000100,
      ST_SRD   = 9'b000001000,
      ST_SCMP  = 9'b000010000,
      ST_WALK  = 9'b000100000,
      ST_WRD   = 9'b001000000,
      ST_WMOD  = 9'b010000000,
      ST_DONE  = 9'b100000000
   } state_type;

   state_type         state_ff, state_in;
   logic              op_ff, op_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [IW-1:0]     home_ff, home_in;
   logic [IW-1:0]     s_ff, s_in;
   logic [IW-1:0]     j_ff, j_in;
   logic [CW-1:0]     n_ff, n_in;
   logic              reins_ff, reins_in;
   logic [TABLE_SIZE-1:0] occ_ff, occ_in;
   rsp_type           res_ff, res_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [KEY_W-1:0]  mem [TABLE_SIZE];
   logic [KEY_W-1:0]  mem_rdata_ff;
   logic [IW-1:0]     mem_raddr;
   logic              mem_we;

   logic              mod_start;
   logic [KEY_W-1:0]  mod_dividend;
   logic              mod_done;
   logic [IW-1:0]     mod_rem;

   function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] s);
      next_slot = (s == LAST_SLOT) ? '0 : s + IW'(1);
   endfunction

   lpht_mod #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dividend),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      home_in      = home_ff;
      s_in         = s_ff;
      j_in         = j_ff;
      n_in         = n_ff;
      reins_in     = reins_ff;
      occ_in       = occ_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      mem_we       = 1'b0;
      mod_start    = 1'b0;
      mod_dividend = req_data.key;
      mem_raddr    = (state_ff == ST_WALK) ? j_ff : s_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in     = req_data.opcode;
               key_in    = req_data.key;
               mod_start = 1'b1;
               state_in  = ST_HMOD;
            end
         end
         ST_HMOD: begin
            if (mod_done) begin
               home_in  = mod_rem;
               s_in     = mod_rem;
               n_in     = '0;
               reins_in = 1'b0;
               state_in = (op_ff == OP_INSERT) ? ST_PLACE : ST_SRD;
            end
         end
         ST_PLACE: begin
            if (!occ_ff[s_ff]) begin
               mem_we       = 1'b1;
               occ_in[s_ff] = 1'b1;
               if (reins_ff) begin
                  j_in     = next_slot(j_ff);
                  state_in = ST_WALK;
               end else begin
                  res_in.status = STATUS_DONE;
                  res_in.slot   = SLOT_W'(s_ff);
                  state_in      = ST_DONE;
               end
            end else if (n_ff == LAST_PROBE) begin
               res_in.status = STATUS_FULL;
               res_in.slot   = '0;
               state_in      = ST_DONE;
            end else begin
               n_in = n_ff + CW'(1);
               s_in = next_slot(s_ff);
            end
         end
         ST_SRD: begin
            if (!occ_ff[s_ff]) begin
               res_in.status = STATUS_NOT_FOUND;
               res_in.slot   = '0;
               state_in      = ST_DONE;
            end else begin
               state_in = ST_SCMP;
            end
         end
         ST_SCMP: begin
            if (mem_rdata_ff == key_ff) begin
               occ_in[s_ff]  = 1'b0;
               res_in.status = STATUS_DONE;
               res_in.slot   = SLOT_W'(s_ff);
               j_in          = next_slot(s_ff);
               state_in      = ST_WALK;
            end else if (n_ff == LAST_PROBE) begin
               res_in.status = STATUS_NOT_FOUND;
               res_in.slot   = '0;
               state_in      = ST_DONE;
            end else begin
               n_in     = n_ff + CW'(1);
               s_in     = next_slot(s_ff);
               state_in = ST_SRD;
            end
         end
         ST_WALK: begin
            if ((j_ff == home_ff) || !occ_ff[j_ff]) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_WRD;
            end
         end
         ST_WRD: begin
            key_in       = mem_rdata_ff;
            mod_dividend = mem_rdata_ff;
            mod_start    = 1'b1;
            state_in     = ST_WMOD;
         end
         ST_WMOD: begin
            if (mod_done) begin
               if (mod_rem != j_ff) begin
                  occ_in[j_ff] = 1'b0;
                  s_in         = mod_rem;
                  n_in         = '0;
                  reins_in     = 1'b1;
                  state_in     = ST_PLACE;
               end else begin
                  j_in     = next_slot(j_ff);
                  state_in = ST_WALK;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff    <= op_in;
      key_ff   <= key_in;
      home_ff  <= home_in;
      s_ff     <= s_in;
      j_ff     <= j_in;
      n_ff     <= n_in;
      reins_ff <= reins_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[s_ff] <= key_ff;
      end
      mem_rdata_ff <= mem[mem_raddr];
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* hw/rtl/lpht_mod.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table home slot unit
// Remainder of a key by the table size through a multiplication by its
// reciprocal, registering the quotient first and then the remainder.
// ----------------------------------------------------------------------------
module lpht_mod
   import lpht_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [KEY_W-1:0]              dividend,
   output logic                          done,
   output logic [$clog2(TABLE_SIZE)-1:0] remainder
);

   localparam int IW    = $clog2(TABLE_SIZE);
   localparam int SHIFT = KEY_W + IW;
   localparam int MW    = KEY_W + 1;
   localparam int PW    = KEY_W + MW;
   localparam int QW    = PW - SHIFT;
   localparam longint unsigned MULT_WIDE =
      ((64'd1 << SHIFT) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
   localparam logic [MW-1:0]    MULT    = MW'(MULT_WIDE);
   localparam logic [KEY_W-1:0] DIVISOR = KEY_W'(TABLE_SIZE);

   logic [PW-1:0]    product;
   logic [KEY_W-1:0] diff;
   logic [QW-1:0]    quot_ff, quot_in;
   logic [KEY_W-1:0] dvd_ff, dvd_in;
   logic [IW-1:0]    rem_ff, rem_in;
   logic             stage_ff;
   logic             done_ff;

   always_comb begin
      quot_in = quot_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      product = PW'(dividend) * PW'(MULT);
      diff    = dvd_ff - KEY_W'(quot_ff) * DIVISOR;
      if (start) begin
         quot_in = product[PW-1:SHIFT];
         dvd_in  = dividend;
      end
      if (stage_ff) begin
         rem_in = diff[IW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= start;
         done_ff  <= stage_ff;
      end
      quot_ff <= quot_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

/* dv/linear_probe_hash_table_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table response monitor
// Follows every accepted request, keeps its own image of the slot table to
// work out the status and slot that each request should return, and compares
// every accepted response against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_monitor
   import lpht_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      error_count,
   output int      pending_count
);

   logic [KEY_W-1:0] stored_key [TABLE_SIZE];
   bit               slot_taken [TABLE_SIZE];
   rsp_type          slot_outcomes [$];

   function automatic int home_slot(logic [KEY_W-1:0] key);
      return int'(key % TABLE_SIZE);
   endfunction

   function automatic int next_slot(int s);
      return (s + 1 >= TABLE_SIZE) ? 0 : s + 1;
   endfunction

   function automatic bit place_key(logic [KEY_W-1:0] key, output int where);
      int s;
      int n;
      s = home_slot(key);
      where = 0;
      for (n = 0; n < TABLE_SIZE; n++) begin
         if (!slot_taken[s]) begin
            stored_key[s] = key;
            slot_taken[s] = 1'b1;
            where = s;
            return 1'b1;
         end
         s = next_slot(s);
      end
      return 1'b0;
   endfunction

   function automatic bit remove_key(logic [KEY_W-1:0] key, output int where);
      int               home;
      int               s;
      int               j;
      int               n;
      int               scratch;
      bit               found;
      logic [KEY_W-1:0] moved;
      home = home_slot(key);
      s = home;
      n = 0;
      found = 1'b0;
      where = 0;
      while (n < TABLE_SIZE && slot_taken[s] && !found) begin
         if (stored_key[s] == key) begin
            found = 1'b1;
         end else begin
            s = next_slot(s);
            n++;
         end
      end
      if (!found) begin
         return 1'b0;
      end
      slot_taken[s] = 1'b0;
      where = s;
      // Entries displaced from their home slot are placed again, in walk order.
      j = next_slot(s);
      while (j != home && slot_taken[j]) begin
         if (home_slot(stored_key[j]) != j) begin
            moved = stored_key[j];
            slot_taken[j] = 1'b0;
            void'(place_key(moved, scratch));
         end
         j = next_slot(j);
      end
      return 1'b1;
   endfunction

   function automatic rsp_type apply_table_op(req_type req);
      rsp_type outcome;
      int      where;
      bit      ok;
      if (req.opcode == OP_INSERT) begin
         ok = place_key(req.key, where);
         outcome.status = ok ? STATUS_DONE : STATUS_FULL;
      end else begin
         ok = remove_key(req.key, where);
         outcome.status = ok ? STATUS_DONE : STATUS_NOT_FOUND;
      end
      outcome.slot = ok ? SLOT_W'(where) : '0;
      return outcome;
   endfunction

   task automatic report_mismatch(string what);
      $display("%0t: response mismatch, %s", $time, what);
      error_count++;
   endtask

   always @(posedge clock) begin
      rsp_type awaited;
      if (reset) begin
         for (int i = 0; i < TABLE_SIZE; i++) begin
            slot_taken[i] = 1'b0;
         end
         slot_outcomes.delete();
         error_count = 0;
         pending_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (slot_outcomes.size() == 0) begin
               report_mismatch($sformatf("status %0d slot %0d with no request outstanding",
                                         rsp_data.status, rsp_data.slot));
            end else begin
               awaited = slot_outcomes.pop_front();
               if (rsp_data.status !== awaited.status) begin
                  report_mismatch($sformatf("status %0d, predicted %0d",
                                            rsp_data.status, awaited.status));
               end
               if (rsp_data.slot !== awaited.slot) begin
                  report_mismatch($sformatf("slot %0d, predicted %0d",
                                            rsp_data.slot, awaited.slot));
               end
            end
         end
         if (req_valid && req_ready) begin
            slot_outcomes.push_back(apply_table_op(req_data));
         end
         pending_count = slot_outcomes.size();
      end
   end

endmodule

/* dv/linear_probe_hash_table_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table testbench
// Drives a directed sequence covering wrap-around, duplicates, cluster
// reinsertion, a full table and absent keys, then clustered random insert and
// delete requests with random gaps and response back-pressure. The monitor
// predicts and checks every response; this module gives the verdict.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_tb;
   import lpht_pkg::*;

   localparam int               TABLE_SIZE  = TABLE_SIZE_DEF;
   localparam int               NUM_RANDOM  = 500;
   localparam int               CYCLE_LIMIT = 2_000_000;
   localparam int               HOLD_CYCLES = 400;
   localparam logic [KEY_W-1:0] KEY_MAX     = '1;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int error_count;
   int pending_count;
   int requests_sent = 0;
   int cycle_count   = 0;
   int hold_left     = 0;
   bit hold_done     = 1'b0;

   logic [KEY_W-1:0] live_keys [$];

   always #5 clock = ~clock;

   linear_probe_hash_table #(
      .TABLE_SIZE(TABLE_SIZE)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   linear_probe_hash_table_monitor #(
      .TABLE_SIZE(TABLE_SIZE)
   ) table_monitor (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .error_count  (error_count),
      .pending_count(pending_count)
   );

   function automatic bit calm_stretch();
      return requests_sent >= 250 && requests_sent < 350;
   endfunction

   function automatic logic [KEY_W-1:0] any_key();
      return KEY_W'($urandom());
   endfunction

   // Homes bunch around the wrap point so that clusters form and cross it.
   function automatic logic [KEY_W-1:0] clustered_key(bit narrow);
      int          h;
      int unsigned upper;
      h = (TABLE_SIZE - 3 + $urandom_range(0, 6)) % TABLE_SIZE;
      upper = narrow ? $urandom_range(0, 3) : $urandom_range(0, 2**24 - 1);
      return KEY_W'(upper * TABLE_SIZE + h);
   endfunction

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && requests_sent >= 120) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (calm_stretch()) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= 6);
      end
   end

   task automatic send_request(logic op, logic [KEY_W-1:0] key);
      int gap;
      if (!calm_stretch() && $urandom_range(0, 99) < 6) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {op, key};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
      @(negedge clock);
   endtask

   initial begin
      int               insert_pct;
      int               pick;
      int               idx;
      logic             op;
      logic [KEY_W-1:0] key;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Three keys share the last home slot and wrap round to the start.
      send_request(OP_INSERT, KEY_MAX);
      send_request(OP_INSERT, KEY_W'(15));
      send_request(OP_INSERT, KEY_W'(31));
      send_request(OP_INSERT, KEY_W'(0));
      send_request(OP_INSERT, KEY_W'(15));
      send_request(OP_DELETE, KEY_MAX);
      send_request(OP_DELETE, KEY_W'(15));
      send_request(OP_DELETE, KEY_W'(12345));
      for (int i = 0; i < 13; i++) begin
         send_request(OP_INSERT, any_key());
      end
      send_request(OP_INSERT, KEY_W'(5));
      send_request(OP_DELETE, KEY_MAX - KEY_W'(1));
      send_request(OP_DELETE, KEY_W'(0));

      insert_pct = 50;
      for (int i = 0; i < NUM_RANDOM; i++) begin
         if (i % 50 == 0) begin
            insert_pct = $urandom_range(25, 85);
         end
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 99) < insert_pct) begin
            op = OP_INSERT;
            if (pick < 20 && live_keys.size() > 0) begin
               key = live_keys[$urandom_range(0, live_keys.size() - 1)];
            end else if (pick < 30) begin
               key = any_key();
            end else begin
               key = clustered_key(pick < 70);
            end
            live_keys.push_back(key);
            if (live_keys.size() > 64) begin
               void'(live_keys.pop_front());
            end
         end else begin
            op = OP_DELETE;
            if (pick < 75 && live_keys.size() > 0) begin
               idx = $urandom_range(0, live_keys.size() - 1);
               key = live_keys[idx];
               live_keys.delete(idx);
            end else if (pick < 85) begin
               key = any_key();
            end else begin
               key = clustered_key(pick < 95);
            end
         end
         send_request(op, key);
      end
      req_valid <= 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/lpht_pkg.sv
hw/rtl/lpht_mod.sv
hw/rtl/linear_probe_hash_table.sv
dv/linear_probe_hash_table_monitor.sv
dv/linear_probe_hash_table_tb.sv
